// File: design/assert_macros.svh
// Assertion macros shared by the tile-map collision design files.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while the reset is active.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is checked through reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/tbcr_pkg.sv
// Package for the tile-map box collision resolver: sizes, codes, types and
// the small arithmetic helpers used by the scan datapath. No dependencies.
package tbcr_pkg;

   // Map geometry. Tiles are a power of two in pixels.
   localparam int TILE_LOG2  = 5;
   localparam int TILE_SIZE  = 1 << TILE_LOG2;
   localparam int MAP_ROWS   = 64;
   localparam int MAP_COLS   = 64;
   localparam int MAX_CHECKS = 16;
   localparam int MAP_DEPTH  = MAP_ROWS * MAP_COLS;
   localparam int ADDR_W     = $clog2(MAP_DEPTH);

   // Field widths.
   localparam int COORD_W    = 11;
   localparam int LEN_W      = 9;
   localparam int DIR_W      = 2;
   localparam int TILE_W     = 8;
   localparam int IN_TILE_W  = 6;
   localparam int OUT_W      = 12;
   localparam int CONTACT_W  = 2;

   // A coordinate plus an extent stays below 2**PIX_W.
   localparam int PIX_W      = COORD_W + 1;
   localparam int TIDX_W     = PIX_W - TILE_LOG2;
   localparam int CNT_W      = $clog2(MAX_CHECKS + 1);
   localparam int SNAP_W     = PIX_W + 1;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;

   // Codes.
   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_RESOLVE = 1'b1;

   localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
   localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;

   localparam logic [CONTACT_W-1:0] CONTACT_NONE  = 2'd0;
   localparam logic [CONTACT_W-1:0] CONTACT_LEFT  = 2'd1;
   localparam logic [CONTACT_W-1:0] CONTACT_RIGHT = 2'd2;
   localparam logic [CONTACT_W-1:0] CONTACT_UP    = 2'd1;
   localparam logic [CONTACT_W-1:0] CONTACT_DOWN  = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DONE
   } tbcr_state_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } tbcr_axis_type;

   // Access request from the controller to the tile store.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [TILE_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } tbcr_mem_req_type;

   // Number of check points along an extent, saturated.
   function automatic logic [CNT_W-1:0] f_check_count(input logic [LEN_W-1:0] len);
      logic [LEN_W:0] rounded;
      logic [LEN_W:0] n;
      rounded = {1'b0, len} + (LEN_W + 1)'(TILE_SIZE - 1);
      n = (rounded >> TILE_LOG2) + (LEN_W + 1)'(1);
      if (n > (LEN_W + 1)'(MAX_CHECKS)) begin
         return CNT_W'(MAX_CHECKS);
      end
      return n[CNT_W-1:0];
   endfunction

   // Pixel position of check point idx out of cnt.
   function automatic logic [PIX_W-1:0] f_check_point(input logic [COORD_W-1:0] base,
                                                      input logic [LEN_W-1:0]   len,
                                                      input logic [CNT_W-1:0]   idx,
                                                      input logic [CNT_W-1:0]   cnt);
      if (idx == '0) begin
         return PIX_W'(base);
      end
      if (idx == cnt - 1'b1) begin
         return PIX_W'(base) + PIX_W'(len) - 1'b1;
      end
      return PIX_W'(base) + (PIX_W'(idx) << TILE_LOG2) - 1'b1;
   endfunction

   // Leading edge on one axis: far edge when moving in the positive direction.
   function automatic logic [PIX_W-1:0] f_lead(input logic [COORD_W-1:0] coord,
                                               input logic [LEN_W-1:0]   size,
                                               input logic               pos);
      if (pos && size != '0) begin
         return PIX_W'(coord) + PIX_W'(size) - 1'b1;
      end
      return PIX_W'(coord);
   endfunction

   // Snapped coordinate against the tile that holds the leading edge.
   function automatic logic signed [OUT_W-1:0] f_snap(input logic [TIDX_W-1:0] lead_tile,
                                                      input logic [LEN_W-1:0]  size,
                                                      input logic              pos);
      logic signed [SNAP_W-1:0] edge_pix;
      logic signed [SNAP_W-1:0] v;
      edge_pix = $signed({1'b0, lead_tile, {TILE_LOG2{1'b0}}});
      if (pos) begin
         v = edge_pix - $signed({{(SNAP_W - LEN_W){1'b0}}, size});
      end else begin
         v = edge_pix + $signed(SNAP_W'(TILE_SIZE));
      end
      if (v > $signed(SNAP_W'(COORD_MAX))) begin
         return OUT_W'(COORD_MAX);
      end
      return v[OUT_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] f_tile_addr(input logic [TIDX_W-1:0] row,
                                                     input logic [TIDX_W-1:0] col);
      return ADDR_W'(row * MAP_COLS + col);
   endfunction

endpackage

// File: design/tbcr_tile_store.sv
// Tile map storage: one synchronous memory with a registered read port and
// a clearing sweep after reset. Depends on tbcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbcr_tile_store import tbcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  tbcr_mem_req_type mem_req,
   output logic [TILE_W-1:0] rd_data,
   output logic             store_ready
);

   logic [TILE_W-1:0] tile_mem [MAP_DEPTH];
   logic [TILE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              clearing_ff;
   logic              clearing_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(MAP_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // The sweep owns the write port until every entry holds zero.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         tile_mem[clr_addr_ff] <= '0;
      end else if (mem_req.wr_en) begin
         tile_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= tile_mem[mem_req.rd_addr];
   end

   assign rd_data     = rd_data_ff;
   assign store_ready = !clearing_ff;

   `ASSERT_ALWAYS(a_reset_starts_sweep, clock, reset |=> clearing_ff && clr_addr_ff == '0, "reset did not restart the clearing sweep")
   `ASSERT_CLK(a_no_write_in_sweep, clock, reset, clearing_ff |-> !mem_req.wr_en, "map write requested during the clearing sweep")
   `ASSERT_CLK(a_sweep_steps, clock, reset, clearing_ff |=> !clearing_ff || clr_addr_ff == $past(clr_addr_ff) + 1'b1, "clearing sweep skipped an entry")
   `ASSERT_CLK(a_sweep_once, clock, reset, !clearing_ff |=> !clearing_ff, "clearing sweep restarted without reset")

endmodule

// File: design/tilemap_box_collision_resolve.sv
// Tile-map box collision resolver. After reset the block first zeroes the
// tile map (req_ready stays low; csr writes are taken at any time). A
// map-write word passes through the done state, which also loads a
// response, before the next word can be accepted. A resolve word checks Ny
// points on the vertical extent when dir_x is non-zero (otherwise that scan
// is absent) and Nx likewise on the horizontal extent when dir_y is
// non-zero; each count is ceil(size / 32) + 1, capped at 16. The scan rate
// is set by the single read port of the tile memory: one check point is
// looked up per cycle, and each axis ends once the registered read of its
// last point returns. Each axis scan stops early at its first solid tile.
// Results leave through an output register, so the next word is accepted
// while a finished result still waits on rsp_ready.
// Depends on tbcr_pkg, tbcr_tile_store and assert_macros.svh.
`include "assert_macros.svh"

module tilemap_box_collision_resolve import tbcr_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,

   // Configuration: passable limit, tile values above it are solid.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [TILE_W-1:0]           csr_passable_limit,

   // Request words.
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [COORD_W-1:0]          req_pos_x,
   input  logic [COORD_W-1:0]          req_pos_y,
   input  logic [COORD_W-1:0]          req_next_x,
   input  logic [COORD_W-1:0]          req_next_y,
   input  logic [LEN_W-1:0]            req_box_width,
   input  logic [LEN_W-1:0]            req_box_height,
   input  logic signed [DIR_W-1:0]     req_dir_x,
   input  logic signed [DIR_W-1:0]     req_dir_y,
   input  logic [IN_TILE_W-1:0]        req_tile_row,
   input  logic [IN_TILE_W-1:0]        req_tile_col,
   input  logic [TILE_W-1:0]           req_tile_value,

   // Response words.
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_W-1:0]     rsp_new_x,
   output logic signed [OUT_W-1:0]     rsp_new_y,
   output logic [CONTACT_W-1:0]        rsp_contact_x,
   output logic [CONTACT_W-1:0]        rsp_contact_y,
   output logic                        rsp_off_map
);

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   tbcr_state_type           state_ff, state_in;
   tbcr_axis_type            axis_ff, axis_in;

   logic [TILE_W-1:0]        limit_ff, limit_in;

   // Captured request.
   logic [COORD_W-1:0]       px_ff, px_in;
   logic [COORD_W-1:0]       py_ff, py_in;
   logic [LEN_W-1:0]         w_ff, w_in;
   logic [LEN_W-1:0]         h_ff, h_in;
   logic                     dx_pos_ff, dx_pos_in;
   logic                     dy_pos_ff, dy_pos_in;
   logic                     dy_nz_ff, dy_nz_in;
   logic [PIX_W-1:0]         lead_x_ff, lead_x_in;
   logic [PIX_W-1:0]         lead_y_ff, lead_y_in;
   logic [CNT_W-1:0]         cnt_x_ff, cnt_x_in;
   logic [CNT_W-1:0]         cnt_y_ff, cnt_y_in;

   // Scan pipeline: issue stage index and the lookup in flight.
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     pt_valid_ff, pt_valid_in;
   logic                     pt_off_ff, pt_off_in;
   logic                     pt_last_ff, pt_last_in;

   // Working result.
   logic signed [OUT_W-1:0]  res_x_ff, res_x_in;
   logic signed [OUT_W-1:0]  res_y_ff, res_y_in;
   logic [CONTACT_W-1:0]     cx_ff, cx_in;
   logic [CONTACT_W-1:0]     cy_ff, cy_in;
   logic                     off_ff, off_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_new_x_ff, rsp_new_x_in;
   logic signed [OUT_W-1:0]  rsp_new_y_ff, rsp_new_y_in;
   logic [CONTACT_W-1:0]     rsp_cx_ff, rsp_cx_in;
   logic [CONTACT_W-1:0]     rsp_cy_ff, rsp_cy_in;
   logic                     rsp_off_ff, rsp_off_in;

   // Combinational control and datapath.
   logic                     req_fire;
   logic                     req_dx_nz;
   logic                     req_dy_nz;
   logic                     out_free;
   logic                     issue;
   logic                     hit;
   logic                     end_axis;
   logic                     load_rsp;
   logic                     wr_in_map;

   logic [COORD_W-1:0]       cur_base;
   logic [LEN_W-1:0]         cur_len;
   logic [LEN_W-1:0]         cur_size;
   logic [CNT_W-1:0]         cur_cnt;
   logic [PIX_W-1:0]         cur_lead;
   logic                     cur_pos;
   logic [PIX_W-1:0]         point;
   logic [TIDX_W-1:0]        pt_tile;
   logic [TIDX_W-1:0]        lead_tile;
   logic [TIDX_W-1:0]        row;
   logic [TIDX_W-1:0]        col;
   logic                     issue_off;
   logic signed [OUT_W-1:0]  snap;

   tbcr_mem_req_type         mem_req;
   logic [TILE_W-1:0]        rd_data;
   logic                     store_ready;

   // ------------------------------------------------------------------
   // Tile memory
   // ------------------------------------------------------------------
   tbcr_tile_store u_store (
      .clock       (clock),
      .reset       (reset),
      .mem_req     (mem_req),
      .rd_data     (rd_data),
      .store_ready (store_ready)
   );

   // ------------------------------------------------------------------
   // Scan datapath
   // ------------------------------------------------------------------
   // The horizontal test walks the vertical extent of the current box at the
   // leading column; the vertical test walks the horizontal extent at the
   // leading row.
   always_comb begin
      if (axis_ff == AXIS_X) begin
         cur_base = py_ff;
         cur_len  = h_ff;
         cur_size = w_ff;
         cur_cnt  = cnt_y_ff;
         cur_lead = lead_x_ff;
         cur_pos  = dx_pos_ff;
      end else begin
         cur_base = px_ff;
         cur_len  = w_ff;
         cur_size = h_ff;
         cur_cnt  = cnt_x_ff;
         cur_lead = lead_y_ff;
         cur_pos  = dy_pos_ff;
      end
      point     = f_check_point(cur_base, cur_len, idx_ff, cur_cnt);
      pt_tile   = point[PIX_W-1:TILE_LOG2];
      lead_tile = cur_lead[PIX_W-1:TILE_LOG2];
      row       = (axis_ff == AXIS_X) ? pt_tile : lead_tile;
      col       = (axis_ff == AXIS_X) ? lead_tile : pt_tile;
      issue_off = (int'(row) >= MAP_ROWS) || (int'(col) >= MAP_COLS);
      snap      = f_snap(lead_tile, cur_size, cur_pos);
   end

   // A lookup that lands in the map and finds a value above the limit ends
   // the axis; so does the last check point.
   assign hit      = pt_valid_ff && !pt_off_ff && (rd_data > limit_ff);
   assign end_axis = pt_valid_ff && (hit || pt_last_ff);

   assign req_dx_nz = (req_dir_x != DIR_ZERO);
   assign req_dy_nz = (req_dir_y != DIR_ZERO);
   assign wr_in_map = (int'(req_tile_row) < MAP_ROWS) && (int'(req_tile_col) < MAP_COLS);

   // ------------------------------------------------------------------
   // Control outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      issue     = (state_ff == S_SCAN) && (idx_ff < cur_cnt) && !end_axis;
      load_rsp  = (state_ff == S_DONE) && out_free;

      // Map writes land at the acceptance edge; scans read only in later
      // cycles, so no scan lookup meets a write to the same entry.
      mem_req.wr_en   = req_fire && (req_action == ACT_WRITE) && wr_in_map;
      mem_req.wr_addr = f_tile_addr(TIDX_W'(req_tile_row), TIDX_W'(req_tile_col));
      mem_req.wr_data = req_tile_value;
      mem_req.rd_addr = f_tile_addr(row, col);
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (store_ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_RESOLVE && (req_dx_nz || req_dy_nz)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (end_axis && (axis_ff == AXIS_Y || !dy_nz_ff)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // ------------------------------------------------------------------
   // Register next values
   // ------------------------------------------------------------------
   always_comb begin
      limit_in    = limit_ff;
      axis_in     = axis_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      dx_pos_in   = dx_pos_ff;
      dy_pos_in   = dy_pos_ff;
      dy_nz_in    = dy_nz_ff;
      lead_x_in   = lead_x_ff;
      lead_y_in   = lead_y_ff;
      cnt_x_in    = cnt_x_ff;
      cnt_y_in    = cnt_y_ff;
      idx_in      = idx_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      off_in      = off_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_passable_limit;
      end

      if (req_fire) begin
         px_in     = req_pos_x;
         py_in     = req_pos_y;
         w_in      = req_box_width;
         h_in      = req_box_height;
         dx_pos_in = (req_dir_x == DIR_POS);
         dy_pos_in = (req_dir_y == DIR_POS);
         dy_nz_in  = req_dy_nz;
         lead_x_in = f_lead(req_next_x, req_box_width, req_dir_x == DIR_POS);
         lead_y_in = f_lead(req_next_y, req_box_height, req_dir_y == DIR_POS);
         cnt_x_in  = f_check_count(req_box_width);
         cnt_y_in  = f_check_count(req_box_height);
         axis_in   = req_dx_nz ? AXIS_X : AXIS_Y;
         idx_in    = '0;
         cx_in     = CONTACT_NONE;
         cy_in     = CONTACT_NONE;
         off_in    = 1'b0;
         if (req_action == ACT_RESOLVE) begin
            res_x_in = $signed(OUT_W'(req_next_x));
            res_y_in = $signed(OUT_W'(req_next_y));
         end else begin
            res_x_in = '0;
            res_y_in = '0;
         end
      end

      if (issue) begin
         idx_in = idx_ff + 1'b1;
      end

      // Only points that were actually examined can raise the off-map flag.
      if (pt_valid_ff && pt_off_ff) begin
         off_in = 1'b1;
      end

      if (hit) begin
         if (axis_ff == AXIS_X) begin
            res_x_in = snap;
            cx_in    = dx_pos_ff ? CONTACT_RIGHT : CONTACT_LEFT;
         end else begin
            res_y_in = snap;
            cy_in    = dy_pos_ff ? CONTACT_DOWN : CONTACT_UP;
         end
      end

      if (end_axis && axis_ff == AXIS_X && dy_nz_ff) begin
         axis_in = AXIS_Y;
         idx_in  = '0;
      end
   end

   assign pt_valid_in = issue;
   assign pt_off_in   = issue_off;
   assign pt_last_in  = (idx_ff == cur_cnt - 1'b1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_new_x_in = rsp_new_x_ff;
      rsp_new_y_in = rsp_new_y_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      rsp_off_in   = rsp_off_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_new_x_in = res_x_ff;
         rsp_new_y_in = res_y_ff;
         rsp_cx_in    = cx_ff;
         rsp_cy_in    = cy_ff;
         rsp_off_in   = off_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         limit_ff     <= '0;
         pt_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= AXIS_X;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         pt_valid_ff  <= pt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      dx_pos_ff    <= dx_pos_in;
      dy_pos_ff    <= dy_pos_in;
      dy_nz_ff     <= dy_nz_in;
      lead_x_ff    <= lead_x_in;
      lead_y_ff    <= lead_y_in;
      cnt_x_ff     <= cnt_x_in;
      cnt_y_ff     <= cnt_y_in;
      pt_off_ff    <= pt_off_in;
      pt_last_ff   <= pt_last_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      off_ff       <= off_in;
      rsp_new_x_ff <= rsp_new_x_in;
      rsp_new_y_ff <= rsp_new_y_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = rsp_new_x_ff;
   assign rsp_new_y     = rsp_new_y_ff;
   assign rsp_contact_x = rsp_cx_ff;
   assign rsp_contact_y = rsp_cy_ff;
   assign rsp_off_map   = rsp_off_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_CLK(a_accept_after_clear, clock, reset, req_valid && req_ready |-> store_ready, "word accepted before the map was cleared")
   `ASSERT_CLK(a_write_when_idle, clock, reset, mem_req.wr_en |-> state_ff == S_IDLE, "map write outside the idle state")
   `ASSERT_CLK(a_idx_in_range, clock, reset, state_ff == S_SCAN |-> idx_ff <= cur_cnt, "check point index ran past the count")
   `ASSERT_CLK(a_lookup_in_scan, clock, reset, pt_valid_ff |-> state_ff == S_SCAN, "tile lookup in flight outside a scan")

endmodule
